@@ hdl/tosc_pkg.sv @@
// shared types and constants for the time ordered sample cache
`timescale 1ns / 1ps
package tosc_pkg;

    localparam int STAMP_W   = 63;
    localparam int PAYLOAD_W = 32;
    localparam int STATUS_W  = 3;
    localparam int COUNT_W   = 6;
    localparam int OP_W      = 2;
    localparam int DEPTH_DEF = 32;

    localparam logic [STAMP_W-1:0] MAX_AGE_RST = 63'd10000000000;

    localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR    = 2'd2;
    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_EMPTY       = 3'd1,
        ST_FUTURE      = 3'd2,
        ST_PAST        = 3'd3,
        ST_TOO_OLD     = 3'd4,
        ST_DUPLICATE   = 3'd5,
        ST_SINGLE_MISS = 3'd6
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_LK_FIRST,
        S_LK_OLD,
        S_SHIFT,
        S_PLACE,
        S_PR_RD,
        S_PR_CMP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0]      operation;
        logic [STAMP_W-1:0]   stamp;
        logic [PAYLOAD_W-1:0] payload;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [PAYLOAD_W-1:0] payload_out;
        logic [COUNT_W-1:0]   entry_count;
    } t_rsp;

    typedef struct packed {
        logic [STAMP_W-1:0]   stamp;
        logic [PAYLOAD_W-1:0] payload;
    } t_entry;

endpackage

@@ hdl/tosc_mem.sv @@
// entry store: one write port, one read port with registered read data
`timescale 1ns / 1ps
module tosc_mem
    import tosc_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/tosc_ctrl.sv @@
// sequencer: search, shift, place, prune and lookup over the entry store
`timescale 1ns / 1ps
module tosc_ctrl
    import tosc_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [STAMP_W-1:0] i_max_age,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  t_req               i_req,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output t_rsp               o_res
);

    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_pos, n_pos;
    logic [STAMP_W-1:0] r_newest, n_newest;
    logic [OP_W-1:0] r_op, n_op;
    logic [STAMP_W-1:0] r_st, n_st;
    logic [PAYLOAD_W-1:0] r_pl, n_pl;
    t_status r_status, n_status;
    logic [PAYLOAD_W-1:0] r_pout, n_pout;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_entry        mem_wdata;
    logic [AW-1:0] mem_raddr;
    t_entry        rdata;

    logic [CW-1:0] idx_inc, idx_dec, cnt_dec;
    logic [STAMP_W:0] req_limit, prune_limit;
    logic scan_more;

    tosc_mem #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(rdata)
    );

    assign idx_inc = r_idx + ONE_C;
    assign idx_dec = r_idx - ONE_C;
    assign cnt_dec = r_cnt - ONE_C;

    // exact 64-bit sums, no overflow possible
    assign req_limit   = {1'b0, i_req.stamp} + {1'b0, i_max_age};
    assign prune_limit = {1'b0, rdata.stamp} + {1'b0, i_max_age};

    // entries are newest first: keep walking while the stored stamp is newer
    assign scan_more = (r_idx < r_cnt) && (rdata.stamp > r_st);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_newest <= n_newest;
        r_op     <= n_op;
        r_st     <= n_st;
        r_pl     <= n_pl;
        r_status <= n_status;
        r_pout   <= n_pout;
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_newest  = r_newest;
        n_op      = r_op;
        n_st      = r_st;
        n_pl      = r_pl;
        n_status  = r_status;
        n_pout    = r_pout;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = rdata;
        mem_raddr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_op     = i_req.operation;
                    n_st     = i_req.stamp;
                    n_pl     = i_req.payload;
                    n_status = ST_OK;
                    n_pout   = '0;
                    n_idx    = '0;
                    n_state  = S_DONE;
                    case (i_req.operation)
                        OP_INSERT: begin
                            if (r_cnt != '0 && {1'b0, r_newest} > req_limit) begin
                                n_status = ST_TOO_OLD;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_LOOKUP: begin
                            if (r_cnt == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_state = S_LK_FIRST;
                            end
                        end
                        OP_CLEAR: begin
                            n_cnt = '0;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_LK_FIRST: begin
                // read data holds the newest entry
                n_state = S_DONE;
                if (r_st == '0) begin
                    n_pout = rdata.payload;
                end else if (r_cnt == ONE_C) begin
                    if (rdata.stamp == r_st) begin
                        n_pout = rdata.payload;
                    end else begin
                        n_status = ST_SINGLE_MISS;
                    end
                end else if (r_st > r_newest) begin
                    n_status = ST_FUTURE;
                end else begin
                    mem_raddr = cnt_dec[AW-1:0];
                    n_state   = S_LK_OLD;
                end
            end

            S_LK_OLD: begin
                if (r_st < rdata.stamp) begin
                    n_status = ST_PAST;
                    n_state  = S_DONE;
                end else begin
                    n_idx   = '0;
                    n_state = S_SCAN;
                end
            end

            S_SCAN: begin
                // reads stream: data for r_idx arrives while r_idx+1 is read
                if (scan_more) begin
                    n_idx     = idx_inc;
                    mem_raddr = idx_inc[AW-1:0];
                end else if (r_op == OP_LOOKUP) begin
                    n_pout  = rdata.payload;
                    n_state = S_DONE;
                end else if (r_idx < r_cnt && rdata.stamp == r_st) begin
                    n_status = ST_DUPLICATE;
                    n_state  = S_DONE;
                end else begin
                    n_pos = r_idx;
                    if (r_idx < r_cnt) begin
                        n_idx     = cnt_dec;
                        mem_raddr = cnt_dec[AW-1:0];
                        n_state   = S_SHIFT;
                    end else begin
                        n_state = S_PLACE;
                    end
                end
            end

            S_SHIFT: begin
                // move entry r_idx one place older, dropping past the end
                mem_we    = (idx_inc < DEPTH_C);
                mem_waddr = idx_inc[AW-1:0];
                mem_wdata = rdata;
                if (r_idx == r_pos) begin
                    n_state = S_PLACE;
                end else begin
                    n_idx     = idx_dec;
                    mem_raddr = idx_dec[AW-1:0];
                end
            end

            S_PLACE: begin
                mem_we    = (r_pos < DEPTH_C);
                mem_waddr = r_pos[AW-1:0];
                mem_wdata = '{stamp: r_st, payload: r_pl};
                if (r_cnt != DEPTH_C) begin
                    n_cnt = r_cnt + ONE_C;
                end
                if (r_pos == '0) begin
                    n_newest = r_st;
                end
                n_state = S_PR_RD;
            end

            S_PR_RD: begin
                mem_raddr = cnt_dec[AW-1:0];
                n_state   = S_PR_CMP;
            end

            S_PR_CMP: begin
                if (prune_limit < {1'b0, r_newest}) begin
                    n_cnt   = cnt_dec;
                    n_state = S_PR_RD;
                end else begin
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_req_ready       = (r_state == S_IDLE);
    assign o_res_valid       = (r_state == S_DONE);
    assign o_res.status      = r_status;
    assign o_res.payload_out = r_pout;
    assign o_res.entry_count = COUNT_W'(r_cnt);

endmodule

@@ hdl/time_ordered_sample_cache.sv @@
// top level: max age register, request sequencer and result register
//
//  channel   direction  handshake                 payload
//  in        input      i_in_valid / o_in_ready   i_in_req   (t_req)
//  out       output     o_out_valid / i_out_ready o_out_rsp  (t_rsp)
//  cfg       input      i_cfg_we                  i_cfg_wdata (max age)
//
// one request at a time: a new request is accepted only once the last result
// has moved on to the output register; insert, duplicate and lookup times grow
// with the entries walked, insert also with each pruned entry, all set by the
// single read port of the entry store walked one entry per cycle
// a finished result sits in the output register while the next request starts
// synchronous active-low reset empties the store and restores the max age
`timescale 1ns / 1ps
module time_ordered_sample_cache
    import tosc_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [STAMP_W-1:0] i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_req               i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_rsp               o_out_rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [STAMP_W-1:0] r_max_age;
    logic r_out_valid;
    t_rsp r_out;

    logic res_valid;
    logic res_ready;
    t_rsp res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_age <= MAX_AGE_RST;
        end else if (i_cfg_we) begin
            r_max_age <= i_cfg_wdata;
        end
    end

    tosc_ctrl #(
        .DEPTH(DEPTH),
        .AW   (AW),
        .CW   (CW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_max_age  (r_max_age),
        .i_req_valid(i_in_valid),
        .o_req_ready(o_in_ready),
        .i_req      (i_in_req),
        .o_res_valid(res_valid),
        .i_res_ready(res_ready),
        .o_res      (res)
    );

    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

endmodule

@@ verif/sample_cache_checker.sv @@
// checker for the sample cache: mirrors the store, predicts each response and compares
`timescale 1ns / 1ps
module sample_cache_checker
    import tosc_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [STAMP_W-1:0] i_cfg_wdata,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  t_req               i_in_req,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  t_rsp               i_out_rsp,
    output int                 o_fail_count,
    output int                 o_pending
);

    logic [STAMP_W-1:0]   age_limit = MAX_AGE_RST;
    // one spare slot so a full store can take the new entry before the oldest is dropped
    logic [STAMP_W-1:0]   cache_stamp   [0:DEPTH];
    logic [PAYLOAD_W-1:0] cache_payload [0:DEPTH];
    int                   n_stored = 0;
    t_rsp                 expected_rsps [$];
    t_rsp                 want;
    int                   fail_count = 0;
    logic                 bad;

    assign o_fail_count = fail_count;

    function automatic t_rsp cache_update(input t_req r);
        t_rsp        rsp;
        int          pos;
        int          k;
        logic [63:0] sum;
        rsp = '0;
        case (r.operation)
            OP_INSERT: begin
                sum = {1'b0, r.stamp} + {1'b0, age_limit};
                if (n_stored > 0 && {1'b0, cache_stamp[0]} > sum) begin
                    rsp.status = ST_TOO_OLD;
                end else begin
                    pos = 0;
                    while (pos < n_stored && cache_stamp[pos] > r.stamp)
                        pos++;
                    if (pos < n_stored && cache_stamp[pos] == r.stamp) begin
                        rsp.status = ST_DUPLICATE;
                    end else begin
                        for (k = n_stored; k > pos; k--) begin
                            cache_stamp[k]   = cache_stamp[k-1];
                            cache_payload[k] = cache_payload[k-1];
                        end
                        cache_stamp[pos]   = r.stamp;
                        cache_payload[pos] = r.payload;
                        n_stored++;
                        if (n_stored > DEPTH)
                            n_stored = DEPTH;
                        // age pruning from the oldest end
                        while (n_stored > 0 &&
                               {1'b0, cache_stamp[n_stored-1]} + {1'b0, age_limit} <
                               {1'b0, cache_stamp[0]})
                            n_stored--;
                        rsp.status = ST_OK;
                    end
                end
            end
            OP_LOOKUP: begin
                if (n_stored == 0) begin
                    rsp.status = ST_EMPTY;
                end else if (r.stamp == '0) begin
                    rsp.status      = ST_OK;
                    rsp.payload_out = cache_payload[0];
                end else if (n_stored == 1) begin
                    if (cache_stamp[0] == r.stamp) begin
                        rsp.status      = ST_OK;
                        rsp.payload_out = cache_payload[0];
                    end else begin
                        rsp.status = ST_SINGLE_MISS;
                    end
                end else if (r.stamp == cache_stamp[0]) begin
                    rsp.status      = ST_OK;
                    rsp.payload_out = cache_payload[0];
                end else if (r.stamp == cache_stamp[n_stored-1]) begin
                    rsp.status      = ST_OK;
                    rsp.payload_out = cache_payload[n_stored-1];
                end else if (r.stamp > cache_stamp[0]) begin
                    rsp.status = ST_FUTURE;
                end else if (r.stamp < cache_stamp[n_stored-1]) begin
                    rsp.status = ST_PAST;
                end else begin
                    pos = 0;
                    while (pos < n_stored - 1 && cache_stamp[pos] > r.stamp)
                        pos++;
                    rsp.status      = ST_OK;
                    rsp.payload_out = cache_payload[pos];
                end
            end
            OP_CLEAR: begin
                n_stored = 0;
            end
            default: begin
            end
        endcase
        rsp.entry_count = n_stored[COUNT_W-1:0];
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            age_limit = MAX_AGE_RST;
            n_stored  = 0;
            expected_rsps.delete();
        end else begin
            if (i_cfg_we)
                age_limit = i_cfg_wdata;
            if (i_in_valid && i_in_ready)
                expected_rsps.push_back(cache_update(i_in_req));
            if (i_out_valid && i_out_ready) begin
                if (expected_rsps.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected response: status %0d payload %h count %0d",
                                 i_out_rsp.status, i_out_rsp.payload_out,
                                 i_out_rsp.entry_count);
                end else begin
                    want = expected_rsps.pop_front();
                    bad  = 1'b0;
                    if (i_out_rsp.status !== want.status)
                        bad = 1'b1;
                    if (i_out_rsp.payload_out !== want.payload_out)
                        bad = 1'b1;
                    if (i_out_rsp.entry_count !== want.entry_count)
                        bad = 1'b1;
                    if (bad) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch: status %0d/%0d payload %h/%h ",
                                      "count %0d/%0d (expected/actual)"},
                                     want.status, i_out_rsp.status,
                                     want.payload_out, i_out_rsp.payload_out,
                                     want.entry_count, i_out_rsp.entry_count);
                    end
                end
            end
        end
        o_pending = expected_rsps.size();
    end

endmodule

@@ verif/testbench.sv @@
// testbench top: drives requests and max age settings into the sample cache and gives the verdict
`timescale 1ns / 1ps
module testbench;
    import tosc_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 150;
    localparam int PHASE_ITEMS  = 72;
    localparam int N_PHASES     = 7;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [STAMP_W-1:0] cfg_wdata = '0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    t_req               in_req    = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    t_rsp               out_rsp;
    int                 fail_count;
    int                 pending;

    int                 burst_left  = 0;
    int                 stall_mode  = 0;
    int                 mode_left   = 0;
    int                 cycle_count = 0;
    logic [STAMP_W-1:0] cur_age     = MAX_AGE_RST;
    logic [STAMP_W-1:0] now_stamp   = '0;
    logic [STAMP_W-1:0] recent_stamps [$];
    logic [STAMP_W-1:0] phase_age [N_PHASES];

    always #2 clk = ~clk;

    time_ordered_sample_cache #(
        .DEPTH(DEPTH_DEF)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_rsp   (out_rsp)
    );

    sample_cache_checker #(
        .DEPTH(DEPTH_DEF)
    ) checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_req     (in_req),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_rsp    (out_rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // receiver: switches between always ready, coin flip and mostly stalled
    always @(posedge clk) begin
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_left  <= $urandom_range(20, 200);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= $urandom_range(0, 1);
            default: out_ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_req make_req(input logic [OP_W-1:0] op,
                                      input logic [STAMP_W-1:0] st,
                                      input logic [PAYLOAD_W-1:0] pl);
        t_req r;
        r.operation = op;
        r.stamp     = st;
        r.payload   = pl;
        return r;
    endfunction

    function automatic logic [STAMP_W-1:0] pick_recent();
        return recent_stamps[$urandom_range(0, recent_stamps.size() - 1)];
    endfunction

    // mostly time-ordered inserts with lookups around the stored window, plus noise
    function automatic t_req next_request();
        t_req        r;
        logic [63:0] base;
        logic [63:0] lim;
        logic [63:0] win;
        logic [63:0] off;
        logic [63:0] sel;
        int          pick;
        r.operation = OP_INSERT;
        r.payload   = $urandom;
        base = (cur_age > 63'h4000_0000_0000) ? 64'h4000_0000_0000 : {1'b0, cur_age};
        lim  = (($urandom_range(0, 4) == 0) ? (base >> 1) : (base >> 6)) + 64'd1;
        win  = base + (base >> 2) + 64'd2;
        sel  = {1'b0, now_stamp};
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            sel       = sel + 64'd1 + (rand64() % lim);
            now_stamp = sel[STAMP_W-1:0];
        end else if (pick < 55) begin
            // out of order, sometimes past the age window
            off = rand64() % win;
            if (off > sel)
                off = sel;
            sel = sel - off;
        end else if (pick < 60) begin
            sel = {1'b0, pick_recent()};
        end else if (pick < 64) begin
            r.operation = OP_LOOKUP;
            sel = '0;
        end else if (pick < 72) begin
            r.operation = OP_LOOKUP;
            sel = {1'b0, pick_recent()};
        end else if (pick < 82) begin
            r.operation = OP_LOOKUP;
            sel = {1'b0, pick_recent()};
            off = rand64() % lim;
            if (off > sel)
                off = sel;
            sel = sel - off;
        end else if (pick < 85) begin
            r.operation = OP_LOOKUP;
            sel = sel + 64'd1 + (rand64() % lim);
        end else if (pick < 88) begin
            r.operation = OP_LOOKUP;
            off = rand64() % (win << 1);
            if (off > sel)
                off = sel;
            sel = sel - off;
        end else if (pick < 91) begin
            r.operation = OP_CLEAR;
        end else if (pick < 93) begin
            r.operation = OP_RESERVED;
            sel = rand64();
        end else begin
            r.operation = OP_W'($urandom_range(0, 3));
            sel = rand64();
        end
        r.stamp = sel[STAMP_W-1:0];
        if (r.operation == OP_INSERT) begin
            recent_stamps.push_back(r.stamp);
            if (recent_stamps.size() > 40)
                void'(recent_stamps.pop_front());
        end
        return r;
    endfunction

    // sender in bursts; valid stays up between requests of one burst
    task automatic send_request(input t_req r);
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        burst_left--;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic write_max_age(input logic [STAMP_W-1:0] value);
        in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending != 0);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we  <= 1'b0;
        cur_age = value;
    endtask

    initial begin
        phase_age[0] = MAX_AGE_RST;
        phase_age[1] = '0;
        phase_age[2] = '1;
        phase_age[3] = 63'd1000;
        phase_age[4] = 63'd200000;
        phase_age[5] = STAMP_W'(rand64());
        phase_age[6] = MAX_AGE_RST;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty store, single entry, range edges, extreme stamps
        send_request(make_req(OP_LOOKUP, '0, '0));
        send_request(make_req(OP_LOOKUP, 63'd5, 32'hFFFF_FFFF));
        send_request(make_req(OP_INSERT, 63'd1000, 32'hFFFF_FFFF));
        send_request(make_req(OP_LOOKUP, 63'd1000, '0));
        send_request(make_req(OP_LOOKUP, 63'd999, '0));
        send_request(make_req(OP_LOOKUP, '0, '0));
        send_request(make_req(OP_INSERT, 63'd1000, 32'h1234_5678));
        send_request(make_req(OP_INSERT, 63'd3000, '0));
        send_request(make_req(OP_INSERT, 63'd2000, 32'hA5A5_A5A5));
        send_request(make_req(OP_LOOKUP, 63'd3000, '0));
        send_request(make_req(OP_LOOKUP, 63'd1000, '0));
        send_request(make_req(OP_LOOKUP, 63'd2500, '0));
        send_request(make_req(OP_LOOKUP, 63'd4000, '0));
        send_request(make_req(OP_LOOKUP, 63'd500, '0));
        send_request(make_req(OP_INSERT, '0, 32'h5A5A_5A5A));
        send_request(make_req(OP_LOOKUP, 63'd1, '0));
        // newest at the top of the range prunes everything else
        send_request(make_req(OP_INSERT, '1, 32'h8000_0001));
        send_request(make_req(OP_INSERT, 63'd5, 32'h0000_0001));
        send_request(make_req(OP_LOOKUP, '1, '0));
        send_request(make_req(OP_RESERVED, '1, 32'hFFFF_FFFF));
        send_request(make_req(OP_CLEAR, '1, 32'hFFFF_FFFF));
        send_request(make_req(OP_LOOKUP, 63'd7, '0));

        for (int p = 0; p < N_PHASES; p++) begin
            if (p > 0)
                write_max_age(phase_age[p]);
            if (p == 2 || $urandom_range(0, 5) == 0)
                now_stamp = {15'h7FE0, $urandom, 16'd0};
            else
                now_stamp = {15'd0, $urandom, 16'd0};
            recent_stamps.delete();
            recent_stamps.push_back(now_stamp);
            send_request(make_req(OP_CLEAR, '0, '0));
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_request(next_request());
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
